/* sv/ms_pkg.sv */
// ms_pkg: sizes and sequencer state codes for the merge sorter core.
// No dependencies; imported by merge_sorter_core.
package ms_pkg;

  localparam int MAX_ELEMS = 64;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  // Fill and batch counts reach MAX_ELEMS itself.
  localparam int FILL_W    = ADDR_W + 1;
  // Merge pointers and widths: lo + 2*width stays below 2*MAX_ELEMS.
  localparam int CNT_W     = ADDR_W + 2;

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_PASS = 8'b0000_0010,
    S_SEG  = 8'b0000_0100,
    S_STEP = 8'b0000_1000,
    S_FILL = 8'b0001_0000,
    S_ERD  = 8'b0010_0000,
    S_ELD  = 8'b0100_0000,
    S_EOUT = 8'b1000_0000
  } ms_state_t;

endpackage

/* sv/ms_ram.sv */
// ms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/merge_sorter_core.sv */
// merge_sorter_core: batch sorter, one shared signed compare under a sequencer.
// Load accepts one beat per cycle. Sort runs bottom-up ping-pong passes between
// two RAMs: one RAM read and one compare per element per pass, plus a segment
// setup step per run pair, ceil(log2 n) passes. Emit reads, loads and shows each
// element in turn, holding it under output stall. Input is stalled from the last
// beat until the final result is taken. rst (sync, active high) clears the fill
// count and control state; RAM contents are not cleared.
module merge_sorter_core
  import ms_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     final_res
);

  ms_state_t state;

  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] n;
  logic [FILL_W-1:0] eidx;
  logic [CNT_W-1:0]  w, lo, mid, hi, l, r, k;
  logic              hl, hr;        // head registers hold data
  logic              fill_side;     // 0: left head, 1: right head
  logic              src_sel;       // 0: read RAM A, write RAM B
  logic [DATA_W-1:0] lv, rv;

  // RAM ports
  logic              a_we, b_we, mrg_we;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, a_rdata, b_rdata, rdata_src;

  logic [CNT_W-1:0]  n_ext, lo_w, lo_2w, seg_mid, seg_hi, l_inc, r_inc;
  logic              l_done, r_done, lneed, rneed, take_left, room;

  assign n_ext     = {1'b0, n};
  assign lo_w      = lo + w;
  assign lo_2w     = lo + (w << 1);
  assign seg_mid   = (lo_w > n_ext) ? n_ext : lo_w;
  assign seg_hi    = (lo_2w > n_ext) ? n_ext : lo_2w;
  assign l_inc     = l + 1'b1;
  assign r_inc     = r + 1'b1;
  assign l_done    = (l == mid);
  assign r_done    = (r == hi);
  assign lneed     = !l_done && !hl;
  assign rneed     = !r_done && !hr;
  // Ties go to the right run.
  assign take_left = r_done || (!l_done && ($signed(lv) < $signed(rv)));
  assign room      = (fill < FILL_W'(MAX_ELEMS));
  assign rdata_src = src_sel ? b_rdata : a_rdata;
  assign in_stall  = (state != S_LOAD);

  // RAM address and write control
  always_comb begin
    mrg_we  = 1'b0;
    a_we    = 1'b0;
    wr_addr = '0;
    wr_data = value;
    rd_addr = '0;
    case (state)
      S_LOAD: begin
        if (in_valid && room) begin
          a_we    = 1'b1;
          wr_addr = fill[ADDR_W-1:0];
        end
      end
      S_STEP: begin
        if (lneed) begin
          rd_addr = l[ADDR_W-1:0];
        end else if (rneed) begin
          rd_addr = r[ADDR_W-1:0];
        end else if (!(l_done && r_done)) begin
          mrg_we  = 1'b1;
          wr_addr = k[ADDR_W-1:0];
          wr_data = take_left ? lv : rv;
          // prefetch the next head of the consumed run
          rd_addr = take_left ? l_inc[ADDR_W-1:0] : r_inc[ADDR_W-1:0];
        end
      end
      S_ERD: begin
        rd_addr = eidx[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
    if (mrg_we && src_sel) begin
      a_we = 1'b1;
    end
    b_we = mrg_we && !src_sel;
  end

  ms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (a_rdata)
  );

  ms_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELEMS)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (b_rdata)
  );

  // Sequencer: load, merge passes, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      fill      <= '0;
      out_valid <= 1'b0;
      hl        <= 1'b0;
      hr        <= 1'b0;
      src_sel   <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (room) begin
              fill <= fill + 1'b1;
            end
            if (last) begin
              n       <= room ? fill + 1'b1 : fill;
              w       <= CNT_W'(1);
              src_sel <= 1'b0;
              state   <= S_PASS;
            end
          end
        end
        S_PASS: begin
          if (w >= n_ext) begin
            eidx  <= '0;
            state <= S_ERD;
          end else begin
            lo    <= '0;
            state <= S_SEG;
          end
        end
        S_SEG: begin
          if (lo < n_ext) begin
            l     <= lo;
            k     <= lo;
            mid   <= seg_mid;
            r     <= seg_mid;
            hi    <= seg_hi;
            hl    <= 1'b0;
            hr    <= 1'b0;
            state <= S_STEP;
          end else begin
            w       <= w << 1;
            src_sel <= ~src_sel;
            state   <= S_PASS;
          end
        end
        S_STEP: begin
          if (lneed) begin
            fill_side <= 1'b0;
            state     <= S_FILL;
          end else if (rneed) begin
            fill_side <= 1'b1;
            state     <= S_FILL;
          end else if (l_done && r_done) begin
            lo    <= lo_2w;
            state <= S_SEG;
          end else begin
            k <= k + 1'b1;
            if (take_left) begin
              l  <= l_inc;
              hl <= 1'b0;
              if (l_inc != mid) begin
                fill_side <= 1'b0;
                state     <= S_FILL;
              end
            end else begin
              r  <= r_inc;
              hr <= 1'b0;
              if (r_inc != hi) begin
                fill_side <= 1'b1;
                state     <= S_FILL;
              end
            end
          end
        end
        S_FILL: begin
          if (fill_side) begin
            rv <= rdata_src;
            hr <= 1'b1;
          end else begin
            lv <= rdata_src;
            hl <= 1'b1;
          end
          state <= S_STEP;
        end
        S_ERD: begin
          state <= S_ELD;
        end
        S_ELD: begin
          sorted_value <= rdata_src;
          final_res    <= ((eidx + 1'b1) == n);
          out_valid    <= 1'b1;
          state        <= S_EOUT;
        end
        S_EOUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (final_res) begin
              fill  <= '0;
              state <= S_LOAD;
            end else begin
              eidx  <= eidx + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_out_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_EOUT))
    else $error("result beat shown outside emit");

  a_ptr_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> (l <= mid && r <= hi && k <= hi && hi <= n_ext))
    else $error("merge pointer out of run bounds");

  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(MAX_ELEMS))
    else $error("fill count beyond capacity");

  a_batch_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && final_res) |=> (fill == '0 && state == S_LOAD))
    else $error("batch did not return to load after final beat");

  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (n != '0 && eidx < n))
    else $error("emit index outside batch");
`endif

endmodule

/* sim/merge_sorter_core_tb.sv */
`timescale 1ns / 1ps
// merge_sorter_core_tb: self-checking testbench for the batch merge sorter.
// Depends on ms_pkg and merge_sorter_core; predicts each sorted batch locally.
module merge_sorter_core_tb
  import ms_pkg::*;
();

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 200;
  localparam int IDLE_PCT     = 32;
  localparam int REPORT_MAX   = 10;

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct packed {
    elem_t value;
    logic  fin;
  } sorted_beat_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  elem_t value = '0;
  logic  last = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  elem_t sorted_value;
  logic  final_res;

  // Local copy of the block's element store
  elem_t        batch_mem [MAX_ELEMS];
  int           batch_fill = 0;
  sorted_beat_t expected_sorted_q [$];

  // Traffic shaping
  bit calm      = 1'b0;
  int hold_req  = 0;
  int hold_left = 0;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int beats_sent     = 0;
  int batches_done   = 0;
  int results_seen   = 0;

  merge_sorter_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last         (last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .final_res    (final_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_sorted_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Store an accepted beat; on the end of a batch sort it and queue the results
  task automatic absorb_element(input elem_t v, input logic is_last);
    elem_t        key;
    int           j;
    sorted_beat_t b;
    if (batch_fill < MAX_ELEMS) begin
      batch_mem[batch_fill] = v;
      batch_fill++;
    end
    if (is_last) begin
      // insertion sort; tie order cannot show in the emitted values
      for (int i = 1; i < batch_fill; i++) begin
        key = batch_mem[i];
        j   = i - 1;
        while (j >= 0 && batch_mem[j] > key) begin
          batch_mem[j + 1] = batch_mem[j];
          j--;
        end
        batch_mem[j + 1] = key;
      end
      for (int i = 0; i < batch_fill; i++) begin
        b.value = batch_mem[i];
        b.fin   = (i == batch_fill - 1);
        expected_sorted_q.push_back(b);
      end
      batch_fill = 0;
      batches_done++;
    end
  endtask

  task automatic report_mismatch(input string what, input elem_t exp_v, input elem_t act_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("MISMATCH @%0t %s: expected %0d (0x%08h) actual %0d (0x%08h)",
               $time, what, exp_v, exp_v, act_v, act_v);
  endtask

  // Send one beat; called and returns at a falling edge, valid stays high
  task automatic send_beat(input elem_t v, input logic is_last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    absorb_element(v, is_last);
    @(negedge clk);
  endtask

  task automatic send_list(input elem_t vals [$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_sorted_q.size() != 0) @(negedge clk);
  endtask

  function automatic elem_t pick_value();
    elem_t t;
    case ($urandom_range(7))
      0: t = {1'b0, {(DATA_W-1){1'b1}}};
      1: t = {1'b1, {(DATA_W-1){1'b0}}};
      2, 3: begin
        t = $urandom_range(8);
        t = t - 4;
      end
      default: t = $urandom;
    endcase
    return t;
  endfunction

  // Receiver: random stalls, a quiet mode, and long hold-offs on request
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Result checker
  always @(posedge clk) begin
    sorted_beat_t exp_b;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_sorted_q.size() == 0) begin
        report_mismatch("unexpected result", '0, sorted_value);
      end else begin
        exp_b = expected_sorted_q.pop_front();
        if (sorted_value !== exp_b.value)
          report_mismatch("sorted_value", exp_b.value, sorted_value);
        if (final_res !== exp_b.fin)
          report_mismatch("final_res", elem_t'(exp_b.fin), elem_t'(final_res));
      end
    end
  end

  // Extremes, single element, duplicates, ordered and reversed input
  task automatic test_directed();
    send_list('{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1});
    send_list('{32'sh80000000});
    send_list('{32'sd42});
    send_list('{32'sd3, 32'sd3, -32'sd3, 32'sd3, -32'sd3});
    send_list('{-32'sd5, -32'sd4, 32'sd0, 32'sd9});
    send_list('{32'sd9, 32'sd0, -32'sd4, -32'sd5});
    drain();
  endtask

  // Full store: MAX_ELEMS kept, then a dropped element and a dropped last
  task automatic test_store_full();
    for (int i = 0; i < MAX_ELEMS; i++) send_beat(pick_value(), 1'b0);
    send_beat(pick_value(), 1'b0);
    send_beat(pick_value(), 1'b1);
    drain();
  endtask

  // Random batches, mostly small, trimmed to the budget
  task automatic test_random_batches(input int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
      if (n > budget - sent) n = budget - sent;
      for (int i = 0; i < n; i++) send_beat($urandom, i == n - 1);
      sent += n;
    end
    drain();
  endtask

  // No idling on either side
  task automatic test_no_idle();
    calm = 1'b1;
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < 6; i++) send_beat(pick_value(), i == 5);
    end
    drain();
    calm = 1'b0;
  endtask

  // Receiver holds off the first batch's results while the sender offers the next
  task automatic test_backpressure();
    hold_req = 400;
    for (int i = 0; i < 4; i++) send_beat(pick_value(), i == 3);
    for (int i = 0; i < 4; i++) send_beat(pick_value(), i == 3);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_store_full();
    test_random_batches(8);
    test_no_idle();
    test_backpressure();

    repeat (TAIL_CYCLES) @(negedge clk);
    while (expected_sorted_q.size() != 0) begin
      report_mismatch("missing result", expected_sorted_q[0].value, '0);
      void'(expected_sorted_q.pop_front());
    end

    $display("Sent %0d beats in %0d batches (full store, drops, extremes, duplicates).",
             beats_sent, batches_done);
    $display("Checked %0d sorted results under random and long output stalls; %0d mismatches.",
             results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
